// ----- sv/kcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Key click detector package
// Shared constants for the key click detector: state, movement and event
// codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package kcd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CLICK_W   = 8;
    localparam int MV_W      = 3;
    localparam int EV_W      = 2;
    localparam int ST_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_GAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LVL  = 2'd2;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd100;
    localparam logic [CFG_W-1:0] SHORT_GAP_RST  = 16'd20;

    localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] ST_PRESS1 = 3'd1;
    localparam logic [ST_W-1:0] ST_REL1   = 3'd2;
    localparam logic [ST_W-1:0] ST_PRESS2 = 3'd3;
    localparam logic [ST_W-1:0] ST_LONG   = 3'd4;

    localparam logic [MV_W-1:0] MV_NONE   = 3'd0;
    localparam logic [MV_W-1:0] MV_DOWN   = 3'd1;
    localparam logic [MV_W-1:0] MV_UP     = 3'd2;
    localparam logic [MV_W-1:0] MV_LSTART = 3'd3;
    localparam logic [MV_W-1:0] MV_LHOLD  = 3'd4;

    localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EV_W-1:0] EV_SINGLE = 2'd1;
    localparam logic [EV_W-1:0] EV_DOUBLE = 2'd2;
    localparam logic [EV_W-1:0] EV_LONG   = 2'd3;

    localparam logic CMD_SCAN  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

endpackage

// ----- sv/key_click_detector.sv -----
// A result beat is registered from its input beat; while the output stalls it waits in the skid entry.
// Throughput: one input beat per cycle while the skid entry is empty; the state update is a single pass.
// A two-entry output stage keeps input accepted while a result waits.
// Reset (synchronous, active low) returns the machine to idle with counters,
// clicks, movement and event cleared, and restores the register defaults.
// ----------------------------------------------------------------------------
// Key click detector
// Single-key click, double-click and long-press detector with a movement
// report per scan tick and a latched event that holds scanning until cleared.
// ----------------------------------------------------------------------------
module key_click_detector
    import kcd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [0] pin_level, [7:1] zero
    input  logic                 s_axis_tuser,  // [0] cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata   // [2:0] movement, [4:3] event_res,
                                                // [12:5] click_count, [15:13] zero
);

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam int RES_W = MV_W + EV_W + CLICK_W;

    logic [CFG_W-1:0]       r_long_press;
    logic [CFG_W-1:0]       r_short_gap;
    logic                   r_press_lvl;

    logic [ST_W-1:0]        r_state,   n_state;
    logic [COUNT_WIDTH-1:0] r_press,   n_press;
    logic [COUNT_WIDTH-1:0] r_release, n_release;
    logic [CLICK_W-1:0]     r_clicks,  n_clicks;
    logic [MV_W-1:0]        r_move,    n_move;
    logic [EV_W-1:0]        r_event,   n_event;

    logic                   r_out_valid, r_skid_valid;
    logic [RES_W-1:0]       r_out_data,  r_skid_data;

    logic                   acc;
    logic                   pressed;
    logic [COUNT_WIDTH-1:0] press_inc, release_inc;
    logic [RES_W-1:0]       res;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign pressed       = (s_axis_tdata[0] == r_press_lvl);
    assign press_inc     = (r_press == {COUNT_WIDTH{1'b1}}) ? r_press : r_press + 1'b1;
    assign release_inc   = (r_release == {COUNT_WIDTH{1'b1}}) ? r_release
                                                              : r_release + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_press   = r_press;
        n_release = r_release;
        n_clicks  = r_clicks;
        n_move    = r_move;
        n_event   = r_event;
        if (s_axis_tuser == CMD_CLEAR) begin
            n_event = EV_NONE;
        end else if (r_event == EV_NONE) begin
            case (r_state)
                ST_PRESS1: begin
                    n_press = press_inc;
                    if (pressed && (CMP_W'(press_inc) > CMP_W'(r_long_press))) begin
                        n_state = ST_LONG;
                        n_move  = MV_LSTART;
                        n_press = '0;
                    end else if (!pressed) begin
                        n_state  = ST_REL1;
                        n_move   = MV_UP;
                        n_clicks = CLICK_W'(1);
                        n_press  = '0;
                    end
                end
                ST_REL1: begin
                    n_release = release_inc;
                    if (!pressed && (CMP_W'(release_inc) > CMP_W'(r_short_gap))) begin
                        n_state = ST_IDLE;
                        n_move  = MV_UP;
                        if (r_clicks == CLICK_W'(1)) begin
                            n_event = EV_SINGLE;
                        end else if (r_clicks == CLICK_W'(2)) begin
                            n_event = EV_DOUBLE;
                        end
                    end else if (pressed) begin
                        n_state   = ST_PRESS2;
                        n_move    = MV_DOWN;
                        n_release = '0;
                    end
                end
                ST_PRESS2: begin
                    n_press = press_inc;
                    if (!pressed) begin
                        if (CMP_W'(press_inc) > CMP_W'(r_short_gap)) begin
                            n_state  = ST_IDLE;
                            n_clicks = '0;
                        end else begin
                            n_state  = ST_REL1;
                            n_clicks = (r_clicks == {CLICK_W{1'b1}}) ? r_clicks
                                                                     : r_clicks + 1'b1;
                        end
                        n_move  = MV_UP;
                        n_press = '0;
                    end
                end
                ST_LONG: begin
                    if (pressed) begin
                        n_move = MV_LHOLD;
                    end else begin
                        n_state = ST_IDLE;
                        n_move  = MV_UP;
                        n_event = EV_LONG;
                    end
                end
                default: begin
                    n_release = '0;
                    if (pressed) begin
                        n_state = ST_PRESS1;
                        n_move  = MV_DOWN;
                    end else begin
                        n_state = ST_IDLE;
                        n_move  = MV_NONE;
                    end
                end
            endcase
        end
    end

    assign res = {n_clicks, n_event, n_move};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press <= LONG_PRESS_RST;
            r_short_gap  <= SHORT_GAP_RST;
            r_press_lvl  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LONG_PRESS: r_long_press <= i_cfg_data;
                REG_SHORT_GAP:  r_short_gap  <= i_cfg_data;
                REG_PRESS_LVL:  r_press_lvl  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_press   <= '0;
            r_release <= '0;
            r_clicks  <= '0;
            r_move    <= MV_NONE;
            r_event   <= EV_NONE;
        end else if (acc) begin
            r_state   <= n_state;
            r_press   <= n_press;
            r_release <= n_release;
            r_clicks  <= n_clicks;
            r_move    <= n_move;
            r_event   <= n_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (acc) begin
                if (r_out_valid && !m_axis_tready) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid_data <= res;
            end else begin
                r_out_data <= res;
            end
        end else if (m_axis_tready && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16 - RES_W){1'b0}}, r_out_data};

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output beat");

    a_latched_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && s_axis_tuser == CMD_SCAN && r_event != EV_NONE)
        |=> ($stable(r_state) && $stable(r_clicks) && $stable(r_move)))
        else $error("scan tick changed state while an event was latched");

    a_clear_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && s_axis_tuser == CMD_CLEAR) |=> (r_event == EV_NONE))
        else $error("clear command left an event latched");

    a_move_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[MV_W-1:0] <= MV_LHOLD))
        else $error("movement code out of range");

endmodule
